// ----- rtl/tmcw_pkg.sv -----
`timescale 1ns / 1ps

package tmcw_pkg;

    // fixed field widths
    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int POS_W  = 11;
    localparam int BYTE_W = 8;
    localparam int CELL_W = 16;

    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CHAR_BLANK   = 8'h20;
    localparam logic [BYTE_W-1:0] COLOR_RESET  = 8'd31;

    // action field codes
    typedef enum logic [1:0] {
        ACT_PUT_CHAR = 2'd0,
        ACT_PUT_CELL = 2'd1,
        ACT_CLEAR    = 2'd2,
        ACT_READ     = 2'd3
    } t_action;

    // classified command for the back end
    typedef enum logic [2:0] {
        OP_PUT     = 3'd0,
        OP_NEWLINE = 3'd1,
        OP_WRITE   = 3'd2,
        OP_READ    = 3'd3,
        OP_CLEAR   = 3'd4,
        OP_OFFSCR  = 3'd5
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [BYTE_W-1:0] ch;
        logic [BYTE_W-1:0] attr;
    } t_cmd;

endpackage

// ----- rtl/tmcw_front.sv -----
`timescale 1ns / 1ps

module tmcw_front #(
    parameter int COLS   = 80,
    parameter int ROWS   = 25,
    parameter int ADDR_W = 11
) (
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [1:0]                 i_action,
    input  logic [tmcw_pkg::BYTE_W-1:0] i_char_code,
    input  logic [tmcw_pkg::BYTE_W-1:0] i_cell_color,
    input  logic [tmcw_pkg::ROW_W-1:0] i_row,
    input  logic [tmcw_pkg::COL_W-1:0] i_col,
    output logic                       o_push_valid,
    input  logic                       i_push_ready,
    output tmcw_pkg::t_cmd             o_cmd,
    output logic [ADDR_W-1:0]          o_addr
);

    logic on_screen;

    assign on_screen    = ({1'b0, i_row} < 6'(ROWS)) && ({1'b0, i_col} < 8'(COLS));
    assign o_ready      = i_push_ready;
    assign o_push_valid = i_valid;

    // position to linear cell address, only meaningful when on screen
    assign o_addr = ADDR_W'(i_row) * ADDR_W'(COLS) + ADDR_W'(i_col);

    always_comb begin
        o_cmd.ch   = i_char_code;
        o_cmd.attr = i_cell_color;
        unique case (tmcw_pkg::t_action'(i_action))
            tmcw_pkg::ACT_PUT_CHAR: begin
                o_cmd.op = (i_char_code == tmcw_pkg::CHAR_NEWLINE) ?
                           tmcw_pkg::OP_NEWLINE : tmcw_pkg::OP_PUT;
            end
            tmcw_pkg::ACT_PUT_CELL: begin
                o_cmd.op = on_screen ? tmcw_pkg::OP_WRITE : tmcw_pkg::OP_OFFSCR;
            end
            tmcw_pkg::ACT_CLEAR: begin
                o_cmd.op = tmcw_pkg::OP_CLEAR;
            end
            tmcw_pkg::ACT_READ: begin
                o_cmd.op = on_screen ? tmcw_pkg::OP_READ : tmcw_pkg::OP_OFFSCR;
            end
            default: begin
                o_cmd.op = tmcw_pkg::OP_OFFSCR;
            end
        endcase
    end

endmodule

// ----- rtl/tmcw_queue.sv -----
`timescale 1ns / 1ps

module tmcw_queue #(
    parameter int ADDR_W = 11
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push_valid,
    output logic                o_push_ready,
    input  tmcw_pkg::t_cmd      i_cmd,
    input  logic [ADDR_W-1:0]   i_addr,
    output logic                o_pop_valid,
    input  logic                i_pop_ready,
    output tmcw_pkg::t_cmd      o_cmd,
    output logic [ADDR_W-1:0]   o_addr
);

    localparam int DEPTH = 2;

    tmcw_pkg::t_cmd    r_cmd  [DEPTH];
    logic [ADDR_W-1:0] r_addr [DEPTH];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != 2'(DEPTH));
    assign o_pop_valid  = (r_count != 2'd0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_cmd        = r_cmd[r_rd_ptr];
    assign o_addr       = r_addr[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_cmd[r_wr_ptr]  <= i_cmd;
            r_addr[r_wr_ptr] <= i_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) r_wr_ptr <= ~r_wr_ptr;
            if (pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/tmcw_back.sv -----
`timescale 1ns / 1ps

module tmcw_back #(
    parameter int COLS   = 80,
    parameter int ROWS   = 25,
    parameter int ADDR_W = 11
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [tmcw_pkg::BYTE_W-1:0] i_text_color,
    input  logic                        i_q_valid,
    output logic                        o_q_ready,
    input  tmcw_pkg::t_cmd              i_cmd,
    input  logic [ADDR_W-1:0]           i_addr,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tmcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]  o_cursor_col,
    output logic [tmcw_pkg::POS_W-1:0]  o_cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0] o_read_cell,
    output logic                        o_scrolled,
    output logic                        o_out_of_range
);

    localparam int CELLS = COLS * ROWS;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_N    = ADDR_W'(COLS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(COLS * (ROWS - 1));
    localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(COLS);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_SCROLL = 6'b000100,
        S_BLANK  = 6'b001000,
        S_CLEAR  = 6'b010000,
        S_FIN    = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [tmcw_pkg::ROW_W-1:0]   r_cur_row, n_cur_row;
    logic [tmcw_pkg::COL_W-1:0]   r_cur_col, n_cur_col;
    logic [ADDR_W-1:0]            r_cur_base, n_cur_base;
    logic [ADDR_W-1:0]            r_sweep, n_sweep;
    logic                         r_fin_scr, n_fin_scr;
    logic                         r_cp_pend;
    logic [ADDR_W-1:0]            r_cp_addr;
    logic [tmcw_pkg::CELL_W-1:0]  r_rd_data;
    logic [tmcw_pkg::CELL_W-1:0]  mem [CELLS];

    logic                         w_en, rd_en;
    logic [ADDR_W-1:0]            w_addr, rd_addr;
    logic [tmcw_pkg::CELL_W-1:0]  w_data, blank_cell;
    logic                         out_free, ld_out, ld_rd, ld_scr, ld_oor, pop;
    logic [tmcw_pkg::POS_W-1:0]   pos_full;
    logic [tmcw_pkg::ROW_W-1:0]   row_inc;
    logic [tmcw_pkg::COL_W:0]     col_inc;
    logic                         last_row;

    logic                         r_o_valid;
    logic [tmcw_pkg::ROW_W-1:0]   r_o_row;
    logic [tmcw_pkg::COL_W-1:0]   r_o_col;
    logic [tmcw_pkg::POS_W-1:0]   r_o_pos;
    logic [tmcw_pkg::CELL_W-1:0]  r_o_cell;
    logic                         r_o_scr;
    logic                         r_o_oor;

    assign out_free   = !r_o_valid || i_out_ready;
    assign blank_cell = {i_text_color, tmcw_pkg::CHAR_BLANK};
    assign row_inc    = r_cur_row + tmcw_pkg::ROW_W'(1);
    assign col_inc    = {1'b0, r_cur_col} + 8'd1;
    assign last_row   = (r_cur_row == tmcw_pkg::ROW_W'(ROWS - 1));
    assign o_q_ready  = pop;

    always_comb begin
        n_state    = r_state;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_cur_base = r_cur_base;
        n_sweep    = r_sweep;
        n_fin_scr  = r_fin_scr;
        pop        = 1'b0;
        w_en       = 1'b0;
        w_addr     = r_cp_addr;
        w_data     = r_rd_data;
        rd_en      = 1'b0;
        rd_addr    = i_addr;
        ld_out     = 1'b0;
        ld_rd      = 1'b0;
        ld_scr     = 1'b0;
        ld_oor     = 1'b0;

        // copy data read in the previous cycle lands one row up
        if (r_cp_pend) begin
            w_en = 1'b1;
        end

        unique case (r_state) inside
            S_IDLE: begin
                if (i_q_valid && out_free) begin
                    pop = 1'b1;
                    unique case (i_cmd.op) inside
                        tmcw_pkg::OP_PUT, tmcw_pkg::OP_NEWLINE: begin
                            if (i_cmd.op == tmcw_pkg::OP_PUT) begin
                                w_en   = 1'b1;
                                w_addr = r_cur_base + ADDR_W'(r_cur_col);
                                w_data = {i_text_color, i_cmd.ch};
                            end
                            if (i_cmd.op == tmcw_pkg::OP_PUT && col_inc != 8'(COLS)) begin
                                n_cur_col = col_inc[tmcw_pkg::COL_W-1:0];
                                ld_out    = 1'b1;
                            end else if (last_row) begin
                                n_cur_col  = '0;
                                n_cur_base = LAST_BASE;
                                n_sweep    = '0;
                                n_fin_scr  = 1'b1;
                                n_state    = S_SCROLL;
                            end else begin
                                n_cur_col  = '0;
                                n_cur_row  = row_inc;
                                n_cur_base = r_cur_base + ROW_STEP;
                                ld_out     = 1'b1;
                            end
                        end
                        tmcw_pkg::OP_WRITE: begin
                            w_en   = 1'b1;
                            w_addr = i_addr;
                            w_data = {i_cmd.attr, i_cmd.ch};
                            ld_out = 1'b1;
                        end
                        tmcw_pkg::OP_READ: begin
                            rd_en   = 1'b1;
                            n_state = S_READ;
                        end
                        tmcw_pkg::OP_CLEAR: begin
                            n_cur_row  = '0;
                            n_cur_col  = '0;
                            n_cur_base = '0;
                            n_sweep    = '0;
                            n_fin_scr  = 1'b0;
                            n_state    = S_CLEAR;
                        end
                        default: begin
                            ld_out = 1'b1;
                            ld_oor = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_rd   = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCROLL: begin
                if (r_sweep != COPY_N) begin
                    rd_en   = 1'b1;
                    rd_addr = r_sweep + ROW_STEP;
                    n_sweep = r_sweep + ADDR_W'(1);
                end else begin
                    n_state = S_BLANK;
                end
            end
            S_BLANK, S_CLEAR: begin
                w_en   = 1'b1;
                w_addr = r_sweep;
                w_data = blank_cell;
                if (r_sweep == LAST_ADDR) begin
                    n_state = S_FIN;
                end else begin
                    n_sweep = r_sweep + ADDR_W'(1);
                end
            end
            S_FIN: begin
                if (out_free) begin
                    ld_out  = 1'b1;
                    ld_scr  = r_fin_scr;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign pos_full = tmcw_pkg::POS_W'(n_cur_base) + tmcw_pkg::POS_W'(n_cur_col);

    // cell store: one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_en) mem[w_addr] <= w_data;
        if (rd_en) r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_cp_addr <= r_sweep;
        if (ld_out) begin
            r_o_row  <= n_cur_row;
            r_o_col  <= n_cur_col;
            r_o_pos  <= pos_full;
            r_o_cell <= ld_rd ? r_rd_data : '0;
            r_o_scr  <= ld_scr;
            r_o_oor  <= ld_oor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_cur_row  <= '0;
            r_cur_col  <= '0;
            r_cur_base <= '0;
            r_sweep    <= '0;
            r_fin_scr  <= 1'b0;
            r_cp_pend  <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cur_row  <= n_cur_row;
            r_cur_col  <= n_cur_col;
            r_cur_base <= n_cur_base;
            r_sweep    <= n_sweep;
            r_fin_scr  <= n_fin_scr;
            r_cp_pend  <= (r_state == S_SCROLL) && (r_sweep != COPY_N);
            if (ld_out) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_cursor_row      = r_o_row;
    assign o_cursor_col      = r_o_col;
    assign o_cursor_position = r_o_pos;
    assign o_read_cell       = r_o_cell;
    assign o_scrolled        = r_o_scr;
    assign o_out_of_range    = r_o_oor;

`ifndef NO_ASSERTIONS
    a_copy_from_scroll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cp_pend |-> $past(r_state == S_SCROLL))
        else $error("copy write pending outside of scroll");

    a_cursor_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cur_row} < 6'(ROWS)) && ({1'b0, r_cur_col} < 8'(COLS)))
        else $error("cursor left the screen");

    a_scroll_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && ld_scr) |=>
            (r_o_row == tmcw_pkg::ROW_W'(ROWS - 1)) && (r_o_col == '0))
        else $error("scroll result not at start of last row");

    a_offscr_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ld_out && ld_oor) |=> (r_o_cell == '0) && !r_o_scr)
        else $error("off-screen result carries data");
`endif

endmodule

// ----- rtl/text_mode_console_writer.sv -----
`timescale 1ns / 1ps

// channel   | handshake                      | payload
// ----------+--------------------------------+---------------------------------------------
// input     | i_in_valid / o_in_ready        | i_action, i_char_code, i_cell_color, i_row,
//           |                                | i_col
// output    | o_out_valid / i_out_ready      | o_cursor_row, o_cursor_col,
//           |                                | o_cursor_position, o_read_cell, o_scrolled,
//           |                                | o_out_of_range
// config    | i_cfg_we (no wait)             | i_cfg_data (text color)
//
// put char, newline, put cell and off-screen items complete in the idle state of the back end,
// except a wrap past the last row, which scrolls; read: registered read of the cell store
// scroll copies rows up and blanks the last row, clear blanks every cell; both are paced by the
// single write port of the cell store, one cell per cycle
// reset (i_rst_n low, synchronous) homes the cursor and sets color 31; cells are
// undefined until written or cleared
// a two-entry queue between front and back lets the input take up to two transfers while the
// back end stalls on a sweep or on a full output register

module text_mode_console_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tmcw_pkg::BYTE_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [1:0]                  i_action,
    input  logic [tmcw_pkg::BYTE_W-1:0] i_char_code,
    input  logic [tmcw_pkg::BYTE_W-1:0] i_cell_color,
    input  logic [tmcw_pkg::ROW_W-1:0]  i_row,
    input  logic [tmcw_pkg::COL_W-1:0]  i_col,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [tmcw_pkg::ROW_W-1:0]  o_cursor_row,
    output logic [tmcw_pkg::COL_W-1:0]  o_cursor_col,
    output logic [tmcw_pkg::POS_W-1:0]  o_cursor_position,
    output logic [tmcw_pkg::CELL_W-1:0] o_read_cell,
    output logic                        o_scrolled,
    output logic                        o_out_of_range
);

    // linear cell address covers the whole screen
    localparam int ADDR_W = $clog2(COLS * ROWS);

    // attribute byte for characters at the cursor and for blanked cells
    logic [tmcw_pkg::BYTE_W-1:0] r_text_color;

    // front to queue
    logic              f_push_valid;
    logic              f_push_ready;
    tmcw_pkg::t_cmd    f_cmd;
    logic [ADDR_W-1:0] f_addr;

    // queue to back
    logic              q_valid;
    logic              q_ready;
    tmcw_pkg::t_cmd    q_cmd;
    logic [ADDR_W-1:0] q_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tmcw_pkg::COLOR_RESET;
        end else if (i_cfg_we) begin
            r_text_color <= i_cfg_data;
        end
    end

    // decode the action, check the target position and form the cell address
    tmcw_front #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_front (
        .i_valid      (i_in_valid),
        .o_ready      (o_in_ready),
        .i_action     (i_action),
        .i_char_code  (i_char_code),
        .i_cell_color (i_cell_color),
        .i_row        (i_row),
        .i_col        (i_col),
        .o_push_valid (f_push_valid),
        .i_push_ready (f_push_ready),
        .o_cmd        (f_cmd),
        .o_addr       (f_addr)
    );

    // decouples transfers on the input from sweeps in the back end
    tmcw_queue #(
        .ADDR_W (ADDR_W)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (f_push_valid),
        .o_push_ready (f_push_ready),
        .i_cmd        (f_cmd),
        .i_addr       (f_addr),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_cmd        (q_cmd),
        .o_addr       (q_addr)
    );

    // cell store, cursor, scroll and clear sweeps, output register
    tmcw_back #(
        .COLS   (COLS),
        .ROWS   (ROWS),
        .ADDR_W (ADDR_W)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_text_color      (r_text_color),
        .i_q_valid         (q_valid),
        .o_q_ready         (q_ready),
        .i_cmd             (q_cmd),
        .i_addr            (q_addr),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_cursor_row      (o_cursor_row),
        .o_cursor_col      (o_cursor_col),
        .o_cursor_position (o_cursor_position),
        .o_read_cell       (o_read_cell),
        .o_scrolled        (o_scrolled),
        .o_out_of_range    (o_out_of_range)
    );

endmodule
